// File: rtl/core/wgm_pkg.sv
// Shared constants, types and helpers for the wildcard glob matcher.
`default_nettype none
package wgm_pkg;

  // Buffer geometry
  localparam int MAX_LEN = 256;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = IDX_W + 1;

  // Request codes carried on in_tuser
  localparam logic [1:0] REQ_CLR_PAT  = 2'd0;
  localparam logic [1:0] REQ_APP_PAT  = 2'd1;
  localparam logic [1:0] REQ_APP_NAME = 2'd2;
  localparam logic [1:0] REQ_EVAL     = 2'd3;

  // Wildcard characters
  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  // Controller to datapath commands
  typedef struct packed {
    logic load_pat;
    logic load_name;
    logic clr_pat;
    logic start;
    logic step;
    logic save;
    logic publish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ovf;
    logic done;
    logic hit;
  } stat_t;

  // Fold ASCII upper case to lower case
  function automatic logic [7:0] fold_letter(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c + 8'h20;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/wildcard_glob_match_core.sv
// Top level of the wildcard glob matcher: controller plus datapath.
//
// Usage: send requests on the in_ stream. in_tuser selects the request:
// clear pattern, append pattern character, append name character, evaluate.
// in_tdata carries the character for append requests. A clear or append
// produces no result. An evaluate produces one result on the out_ stream:
// bit 0 matched, bit 1 overflowed; the name buffer and the overflow flag
// are then cleared, the pattern is kept.
// Evaluation walks the greedy single-star backtrack step by step: a fetch
// state for registered reads of the pattern and name memories, then a
// compare state that makes the decision. An overflowed evaluate skips the
// walk and goes straight to the result.
// in_tready is low while an evaluate runs. A result waiting in the output
// register does not stop loads; a following evaluate holds its result
// until the receiver takes the earlier one.
// cfg_data bit sets case-insensitive compare, cfg_ready is always high.
// Synchronous reset empties both buffers, clears overflow, drops any pending
// result and sets case-insensitive mode.
`default_nettype none
module wildcard_glob_match_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_value
  input  wire logic [1:0] in_tuser,   // [1:0] req_type
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [0] matched, [1] overflowed, [7:2] zero
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data    // case_insensitive
);

  wgm_pkg::cmd_t  cmd;
  wgm_pkg::stat_t stat;
  logic           matched, overflowed;

  assign cfg_ready = 1'b1;

  wgm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req_type   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  wgm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .char_value (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_bit    (cfg_data),
    .matched    (matched),
    .overflowed (overflowed)
  );

  assign out_tdata = {6'b0, overflowed, matched};

endmodule
`default_nettype wire

// File: rtl/core/wgm_datapath.sv
// Datapath: pattern and name stores, lengths, match indices and result registers.
`default_nettype none
module wgm_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire wgm_pkg::cmd_t cmd,
  output wgm_pkg::stat_t     stat,
  input  wire logic [7:0]    char_value,
  input  wire logic          cfg_we,
  input  wire logic          cfg_bit,
  output logic               matched,
  output logic               overflowed
);

  localparam int IW = wgm_pkg::IDX_W;
  localparam int LW = wgm_pkg::LEN_W;
  localparam logic [LW-1:0] MAXL = LW'(wgm_pkg::MAX_LEN);
  localparam logic [LW-1:0] ONE  = LW'(1);

  // Storage
  logic [7:0] pstore [wgm_pkg::MAX_LEN];
  logic [7:0] nstore [wgm_pkg::MAX_LEN];
  logic [7:0] p_rd_r, n_rd_r;

  logic [LW-1:0] plen_r, plen_nxt, nlen_r, nlen_nxt;
  logic          ovf_r, ovf_nxt;
  logic          ci_r;

  // Match state
  logic [LW-1:0] pi_r, pi_nxt, ni_r, ni_nxt;
  logic [LW-1:0] star_r, star_nxt, retry_r, retry_nxt;
  logic          have_star_r, have_star_nxt;
  logic          res_hit_r, res_ovf_r;
  logic          out_hit_r, out_ovf_r;

  logic done, hit;
  logic p_ok, n_end, is_star, is_any, eq;

  // Memory writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.load_pat && plen_r < MAXL) pstore[plen_r[IW-1:0]] <= char_value;
    if (cmd.load_name && nlen_r < MAXL) nstore[nlen_r[IW-1:0]] <= char_value;
    p_rd_r <= pstore[pi_r[IW-1:0]];
    n_rd_r <= nstore[ni_r[IW-1:0]];
  end

  // Length and overflow bookkeeping
  always_comb begin
    plen_nxt = plen_r;
    nlen_nxt = nlen_r;
    ovf_nxt  = ovf_r;
    if (cmd.clr_pat) begin
      plen_nxt = '0;
      ovf_nxt  = 1'b0;
    end
    if (cmd.load_pat) begin
      if (plen_r < MAXL) plen_nxt = plen_r + ONE;
      else ovf_nxt = 1'b1;
    end
    if (cmd.load_name) begin
      if (nlen_r < MAXL) nlen_nxt = nlen_r + ONE;
      else ovf_nxt = 1'b1;
    end
    if (cmd.publish) begin
      nlen_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  // One backtracking step, decided on the fetched characters
  always_comb begin
    p_ok    = pi_r < plen_r;
    n_end   = ni_r >= nlen_r;
    is_star = p_ok && (p_rd_r == wgm_pkg::STAR_CHAR);
    is_any  = p_ok && (p_rd_r == wgm_pkg::ANY_CHAR);
    eq      = ci_r ? (wgm_pkg::fold_letter(p_rd_r) == wgm_pkg::fold_letter(n_rd_r))
                   : (p_rd_r == n_rd_r);
    done          = 1'b0;
    hit           = 1'b0;
    pi_nxt        = pi_r;
    ni_nxt        = ni_r;
    star_nxt      = star_r;
    retry_nxt     = retry_r;
    have_star_nxt = have_star_r;
    if (!n_end) begin
      if (is_any) begin
        pi_nxt = pi_r + ONE;
        ni_nxt = ni_r + ONE;
      end else if (is_star) begin
        pi_nxt = pi_r + ONE;
        if (pi_r + ONE >= plen_r) begin
          done = 1'b1;
          hit  = 1'b1;
        end else begin
          have_star_nxt = 1'b1;
          star_nxt      = pi_r + ONE;
          retry_nxt     = ni_r + ONE;
        end
      end else if (p_ok && eq) begin
        pi_nxt = pi_r + ONE;
        ni_nxt = ni_r + ONE;
      end else if (!have_star_r) begin
        done = 1'b1;
      end else begin
        pi_nxt    = star_r;
        ni_nxt    = retry_r;
        retry_nxt = retry_r + ONE;
      end
    end else begin
      // name consumed: only trailing stars may remain
      if (!p_ok) begin
        done = 1'b1;
        hit  = 1'b1;
      end else if (is_star) begin
        pi_nxt = pi_r + ONE;
      end else begin
        done = 1'b1;
      end
    end
    if (cmd.start) begin
      pi_nxt        = '0;
      ni_nxt        = '0;
      star_nxt      = '0;
      retry_nxt     = '0;
      have_star_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      nlen_r      <= '0;
      ovf_r       <= 1'b0;
      ci_r        <= 1'b1;
      have_star_r <= 1'b0;
    end else begin
      plen_r      <= plen_nxt;
      nlen_r      <= nlen_nxt;
      ovf_r       <= ovf_nxt;
      have_star_r <= (cmd.step || cmd.start) ? have_star_nxt : have_star_r;
      if (cfg_we) ci_r <= cfg_bit;
    end
  end

  // Index and result registers
  always_ff @(posedge clk) begin
    if (cmd.step || cmd.start) begin
      pi_r    <= pi_nxt;
      ni_r    <= ni_nxt;
      star_r  <= star_nxt;
      retry_r <= retry_nxt;
    end
    if (cmd.start) begin
      res_hit_r <= 1'b0;
      res_ovf_r <= ovf_r;
    end
    if (cmd.save) res_hit_r <= hit;
    if (cmd.publish) begin
      out_hit_r <= res_hit_r;
      out_ovf_r <= res_ovf_r;
    end
  end

  assign stat.ovf    = ovf_r;
  assign stat.done   = done;
  assign stat.hit    = hit;
  assign matched     = out_hit_r;
  assign overflowed  = out_ovf_r;

endmodule
`default_nettype wire

// File: rtl/core/wgm_ctrl.sv
// Controller: request decode, match sequencing and output handshake.
`default_nettype none
module wgm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [1:0]     req_type,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output wgm_pkg::cmd_t       cmd,
  input  wire wgm_pkg::stat_t stat
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc, slot_free;

  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (req_type)
            wgm_pkg::REQ_CLR_PAT:  cmd.clr_pat   = 1'b1;
            wgm_pkg::REQ_APP_PAT:  cmd.load_pat  = 1'b1;
            wgm_pkg::REQ_APP_NAME: cmd.load_name = 1'b1;
            wgm_pkg::REQ_EVAL: begin
              cmd.start = 1'b1;
              state_nxt = stat.ovf ? ST_DONE : ST_FETCH;
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: state_nxt = ST_CMP;
      ST_CMP: begin
        if (stat.done) begin
          cmd.save  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// File: rtl/core/wgm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to the top level.
`default_nettype none
module wgm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [1:0] in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // An overflowed evaluation never reports a match
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("match reported on overflow");

  // An accepted evaluate request makes the block busy and drops in_tready
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == wgm_pkg::REQ_EVAL) |=> !in_tready)
    else $error("request taken during evaluation");

  // Reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind wildcard_glob_match_core wgm_checker u_wgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: tb/sv/tb_wildcard_glob_match_core.sv
// Self-checking testbench for the wildcard glob matcher core.
`timescale 1ns / 100ps
module tb_wildcard_glob_match_core;

  localparam int LONG_STALL = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 70;
  localparam int N_DIRECTED = 27;

  typedef struct packed {
    logic matched;
    logic overflowed;
  } verdict_t;

  // One row of the directed table; typed rows carry a hand-written verdict
  typedef struct packed {
    logic [1:0] req;
    logic [7:0] ch;
    logic [9:0] reps;
    logic       typed;
    logic       m;
    logic       o;
  } dir_row_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] char_value
  logic [1:0] in_tuser = 2'b00;   // [1:0] req_type
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] matched, [1] overflowed, [7:2] zero
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  // Shadow of the matcher state
  logic [7:0] pat_mem [wgm_pkg::MAX_LEN];
  logic [7:0] name_mem [wgm_pkg::MAX_LEN];
  int         pat_len = 0;
  int         name_len = 0;
  logic       ovf_flag = 1'b0;
  logic       fold_case = 1'b1;

  verdict_t   pending_verdicts [$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         evals_seen = 0;
  int         hits_seen = 0;
  int         ovfs_seen = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         stall_asked = 0;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{wgm_pkg::REQ_EVAL,     8'h5A, 10'd1,   1'b1, 1'b1, 1'b0},  // empty pattern, empty name
    '{wgm_pkg::REQ_APP_NAME, 8'h71, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_EVAL,     8'h00, 10'd1,   1'b1, 1'b0, 1'b0},  // empty pattern, one-char name
    '{wgm_pkg::REQ_APP_PAT,  wgm_pkg::STAR_CHAR, 10'd1, 1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_EVAL,     8'hFF, 10'd1,   1'b1, 1'b1, 1'b0},  // empty name vs lone star
    '{wgm_pkg::REQ_APP_PAT,  wgm_pkg::ANY_CHAR, 10'd1, 1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_APP_NAME, 8'h00, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_APP_NAME, 8'hFF, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_EVAL,     8'h00, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_CLR_PAT,  8'hFF, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_APP_PAT,  8'h41, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_APP_PAT,  wgm_pkg::STAR_CHAR, 10'd1, 1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_APP_PAT,  8'h62, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_APP_NAME, 8'h61, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_APP_NAME, 8'h78, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_APP_NAME, 8'h42, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_EVAL,     8'hA5, 10'd1,   1'b0, 1'b0, 1'b0},  // case folded letters
    '{wgm_pkg::REQ_CLR_PAT,  8'h00, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_APP_PAT,  8'h7A, 10'd257, 1'b0, 1'b0, 1'b0},  // pattern one past full
    '{wgm_pkg::REQ_EVAL,     8'h3C, 10'd1,   1'b1, 1'b0, 1'b1},
    '{wgm_pkg::REQ_APP_NAME, 8'h5A, 10'd256, 1'b0, 1'b0, 1'b0},  // full name vs kept pattern
    '{wgm_pkg::REQ_EVAL,     8'h00, 10'd1,   1'b0, 1'b0, 1'b0},
    '{wgm_pkg::REQ_APP_NAME, 8'h7A, 10'd257, 1'b0, 1'b0, 1'b0},  // name one past full
    '{wgm_pkg::REQ_EVAL,     8'hFF, 10'd1,   1'b1, 1'b0, 1'b1},
    '{wgm_pkg::REQ_APP_PAT,  8'h78, 10'd1,   1'b0, 1'b0, 1'b0},  // pattern overflow again
    '{wgm_pkg::REQ_CLR_PAT,  8'h5A, 10'd1,   1'b0, 1'b0, 1'b0},  // clear drops the overflow
    '{wgm_pkg::REQ_EVAL,     8'h00, 10'd1,   1'b1, 1'b1, 1'b0}
  };

  wildcard_glob_match_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic chars_agree(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] fa;
    logic [7:0] fb;
    fa = a;
    fb = b;
    if (fold_case) begin
      if (a >= 8'h41 && a <= 8'h5A) fa = a + 8'h20;
      if (b >= 8'h41 && b <= 8'h5A) fb = b + 8'h20;
    end
    return fa == fb;
  endfunction

  // Greedy single-star backtrack over the shadow buffers
  function automatic logic glob_hit();
    int  pi;
    int  ni;
    int  star_next;
    int  name_retry;
    logic have_star;
    pi = 0;
    ni = 0;
    star_next = 0;
    name_retry = 0;
    have_star = 1'b0;
    while (ni < name_len) begin
      if (pi < pat_len && pat_mem[pi] == wgm_pkg::ANY_CHAR) begin
        pi++;
        ni++;
      end else if (pi < pat_len && pat_mem[pi] == wgm_pkg::STAR_CHAR) begin
        pi++;
        if (pi >= pat_len) return 1'b1;
        have_star = 1'b1;
        star_next = pi;
        name_retry = ni + 1;
      end else if (pi < pat_len && chars_agree(pat_mem[pi], name_mem[ni])) begin
        pi++;
        ni++;
      end else begin
        if (!have_star) return 1'b0;
        pi = star_next;
        ni = name_retry;
        name_retry++;
      end
    end
    while (pi < pat_len && pat_mem[pi] == wgm_pkg::STAR_CHAR) pi++;
    return pi >= pat_len;
  endfunction

  // Apply one request to the shadow state; returns 1 when a verdict is due
  function automatic logic track_request(input logic [1:0] req, input logic [7:0] ch,
                                         output verdict_t v);
    v = '0;
    case (req)
      wgm_pkg::REQ_CLR_PAT: begin
        pat_len = 0;
        ovf_flag = 1'b0;
      end
      wgm_pkg::REQ_APP_PAT: begin
        if (pat_len < wgm_pkg::MAX_LEN) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      wgm_pkg::REQ_APP_NAME: begin
        if (name_len < wgm_pkg::MAX_LEN) begin
          name_mem[name_len] = ch;
          name_len++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      default: begin
        v.overflowed = ovf_flag;
        v.matched = ovf_flag ? 1'b0 : glob_hit();
        name_len = 0;
        ovf_flag = 1'b0;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch: %s", what);
  endtask

  // Offer one request, with random idle cycles ahead of it
  task automatic send_req(input logic [1:0] req, input logic [7:0] ch,
                          input logic typed = 1'b0, input verdict_t typed_v = '0);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= ch;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (track_request(req, ch, v)) begin
      if (typed) v = typed_v;
      pending_verdicts = {pending_verdicts, v};
    end
  endtask

  // Stop offering and let every outstanding verdict come back
  task automatic drain_verdicts();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_case_mode(input logic v);
    drain_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fold_case = v;
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(4))
      0: return 8'h61;
      1: return 8'h41;
      2: return 8'h62;
      3: return 8'h42;
      default: return 8'h63;
    endcase
  endfunction

  function automatic logic [7:0] pick_pat_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 22) return wgm_pkg::STAR_CHAR;
    if (roll < 36) return wgm_pkg::ANY_CHAR;
    if (roll < 88) return pick_letter();
    return 8'($urandom_range(255));
  endfunction

  // One pattern/name/evaluate sequence, or a burst of noise
  task automatic send_glob_case();
    int roll;
    int plen;
    int k;
    logic [7:0] c;
    roll = $urandom_range(99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 4)) send_req(2'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    // rare overrun of one buffer
    if ($urandom_range(59) == 0) begin
      if ($urandom_range(1) != 0) begin
        repeat (wgm_pkg::MAX_LEN + 1 + $urandom_range(3))
          send_req(wgm_pkg::REQ_APP_NAME, 8'($urandom_range(255)));
      end else begin
        send_req(wgm_pkg::REQ_CLR_PAT, 8'($urandom_range(255)));
        repeat (wgm_pkg::MAX_LEN + 1 + $urandom_range(3))
          send_req(wgm_pkg::REQ_APP_PAT, pick_pat_char());
      end
      send_req(wgm_pkg::REQ_EVAL, 8'($urandom_range(255)));
      return;
    end
    // new pattern most of the time, otherwise keep a short stored one
    if ($urandom_range(99) < 75 || pat_len > 20) begin
      send_req(wgm_pkg::REQ_CLR_PAT, 8'($urandom_range(255)));
      plen = ($urandom_range(19) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      repeat (plen) send_req(wgm_pkg::REQ_APP_PAT, pick_pat_char());
    end
    if ($urandom_range(99) < 55) begin
      // name shaped after the pattern, with the odd corruption
      for (k = 0; k < pat_len; k++) begin
        c = pat_mem[k];
        if (c == wgm_pkg::STAR_CHAR) begin
          repeat ($urandom_range(2)) send_req(wgm_pkg::REQ_APP_NAME, pick_letter());
        end else begin
          if (c == wgm_pkg::ANY_CHAR || $urandom_range(19) == 0) c = 8'($urandom_range(255));
          else if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(1) != 0)
            c = c ^ 8'h20;
          send_req(wgm_pkg::REQ_APP_NAME, c);
        end
      end
    end else begin
      repeat ($urandom_range(8)) send_req(wgm_pkg::REQ_APP_NAME, pick_letter());
    end
    send_req(wgm_pkg::REQ_EVAL, 8'($urandom_range(255)));
  endtask

  // Result side: check each accepted verdict, then pick the next tready
  initial begin : verdict_sink
    int stall_left;
    int stall_seen;
    verdict_t want;
    stall_left = 0;
    stall_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_verdicts.size() == 0) begin
          note_mismatch($sformatf("unexpected result tdata=%02h", out_tdata));
        end else begin
          want = pending_verdicts.pop_front();
          evals_seen++;
          if (want.matched) hits_seen++;
          if (want.overflowed) ovfs_seen++;
          if (out_tdata[0] !== want.matched)
            note_mismatch($sformatf("eval %0d matched exp %0b got %0b",
                                    evals_seen, want.matched, out_tdata[0]));
          if (out_tdata[1] !== want.overflowed)
            note_mismatch($sformatf("eval %0d overflowed exp %0b got %0b",
                                    evals_seen, want.overflowed, out_tdata[1]));
          if (out_tdata[7:2] !== 6'd0)
            note_mismatch($sformatf("eval %0d pad bits exp 0 got %02h",
                                    evals_seen, out_tdata[7:2]));
        end
      end
      if (stall_seen != stall_asked) begin
        stall_seen = stall_asked;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Request side
  initial begin : request_source
    int  i;
    int  phase;
    int  phase_goal;
    int  midpoint;
    logic pressed;
    logic ci_plan [6];
    ci_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, folding at its reset setting
    for (i = 0; i < N_DIRECTED; i++) begin
      repeat (dir_rows[i].reps)
        send_req(dir_rows[i].req, dir_rows[i].ch, dir_rows[i].typed,
                 '{matched: dir_rows[i].m, overflowed: dir_rows[i].o});
    end

    // random phases: idle mix changes every two phases, folding is written every phase
    for (phase = 0; phase < 6; phase++) begin
      write_case_mode(ci_plan[phase]);
      case (phase / 2)
        0: begin send_idle_pct = 28; recv_idle_pct = 73; end
        1: begin send_idle_pct = 73; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_goal = items_sent + PHASE_ITEMS;
      midpoint = items_sent + PHASE_ITEMS / 2;
      pressed = 1'b0;
      while (items_sent < phase_goal) begin
        if (!pressed && items_sent >= midpoint) begin
          pressed = 1'b1;
          if (phase == 1) stall_asked++;
          if (phase == 4) drain_verdicts();
        end
        send_glob_case();
      end
    end

    drain_verdicts();
    repeat (40) @(posedge clk);
    $display("tb: %0d requests, %0d evaluations checked (%0d matched, %0d overflowed)",
             items_sent, evals_seen, hits_seen, ovfs_seen);
    $display("tb: case folding on and off, three idle mixes, one long result stall");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/wgm_pkg.sv
rtl/core/wgm_datapath.sv
rtl/core/wgm_ctrl.sv
rtl/core/wildcard_glob_match_core.sv
rtl/core/wgm_checker.sv
tb/sv/tb_wildcard_glob_match_core.sv
